FILE: rtl/vtpo_pkg.sv
package vtpo_pkg;

   localparam int unsigned DivSteps = 34;

   localparam logic [2:0] RegRow0Xy     = 3'd0;
   localparam logic [2:0] RegRow0Zt     = 3'd1;
   localparam logic [2:0] RegRow1Xy     = 3'd2;
   localparam logic [2:0] RegRow1Zt     = 3'd3;
   localparam logic [2:0] RegRow2Xy     = 3'd4;
   localparam logic [2:0] RegRow2Zt     = 3'd5;
   localparam logic [2:0] RegHalfWindow = 3'd6;
   localparam logic [2:0] RegClipMode   = 3'd7;

   // screen term cap (2^33) and inverse depth numerator (2^40)
   localparam logic [34:0] TermCap = 35'h2_0000_0000;
   localparam logic [63:0] InvNum  = 64'h0000_0100_0000_0000;

   typedef logic [5:0][63:0] matrix_type;

   typedef struct packed {
      logic               wanted;
      logic               last;
      logic               cam_sat;
      logic [3:0]         code;
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
   } cam_type;

   typedef struct packed {
      cam_type     cam;
      logic        proj;
      logic        zero_z;
      logic        neg_z;
      logic        zero_nx;
      logic        zero_ny;
      logic        neg_x;
      logic        neg_y;
      logic [15:0] wx;
      logic [15:0] wy;
      logic [2:0]  ovf;
   } side_type;

endpackage

FILE: rtl/vtpo_xform.sv
module vtpo_xform (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [31:0]    in_x,
   input  logic signed [31:0]    in_y,
   input  logic signed [31:0]    in_z,
   input  logic                  in_wanted,
   input  logic                  in_last,
   input  vtpo_pkg::matrix_type  matrix,
   input  logic                  clip_mode,
   output logic                  out_valid,
   output vtpo_pkg::cam_type     cam
);

   logic signed [31:0] vec [3];
   logic signed [31:0] coef [3][3];
   logic signed [31:0] trans [3];
   logic signed [63:0] prod_ff [3][3];
   logic valid1_ff, wanted1_ff, last1_ff;
   logic signed [65:0] acc [3];
   logic signed [49:0] sum_in [3];
   logic signed [49:0] sum_ff [3];
   logic valid2_ff, wanted2_ff, last2_ff;
   logic signed [31:0] clamp [3];
   logic [2:0] hit;
   logic [3:0] code;
   logic valid3_ff;
   vtpo_pkg::cam_type cam_ff;

   assign vec[0] = in_x;
   assign vec[1] = in_y;
   assign vec[2] = in_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coef[r][0] = matrix[2*r][31:0];
         coef[r][1] = matrix[2*r][63:32];
         coef[r][2] = matrix[2*r+1][31:0];
         trans[r]   = matrix[2*r+1][63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r][c] <= coef[r][c] * vec[c];
         end
      end
      wanted1_ff <= in_wanted;
      last1_ff   <= in_last;
   end

   // exact Q34.32 sum, round half up to Q16.16
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = (66'(trans[r]) <<< 16) + 66'(prod_ff[r][0]) + 66'(prod_ff[r][1])
                + 66'(prod_ff[r][2]) + 66'sd32768;
         sum_in[r] = acc[r][65:16];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         sum_ff[r] <= sum_in[r];
      end
      wanted2_ff <= wanted1_ff;
      last2_ff   <= last1_ff;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (sum_ff[r] > 50'sd2147483647) begin
            clamp[r] = 32'sh7fff_ffff;
            hit[r]   = 1'b1;
         end else if (sum_ff[r] < -50'sd2147483648) begin
            clamp[r] = 32'sh8000_0000;
            hit[r]   = 1'b1;
         end else begin
            clamp[r] = sum_ff[r][31:0];
            hit[r]   = 1'b0;
         end
      end
      code = 4'd0;
      if (clip_mode) begin
         code[0] = 33'(clamp[0]) < -33'(clamp[2]);
         code[1] = 33'(clamp[0]) > 33'(clamp[2]);
         code[2] = 33'(clamp[1]) < -33'(clamp[2]);
         code[3] = 33'(clamp[1]) > 33'(clamp[2]);
      end
   end

   always_ff @(posedge clock) begin
      cam_ff.wanted  <= wanted2_ff;
      cam_ff.last    <= last2_ff;
      cam_ff.cam_sat <= |hit;
      cam_ff.code    <= code;
      cam_ff.cam_x   <= clamp[0];
      cam_ff.cam_y   <= clamp[1];
      cam_ff.cam_z   <= clamp[2];
   end

   assign out_valid = valid3_ff;
   assign cam       = cam_ff;

endmodule

FILE: rtl/vtpo_div.sv
module vtpo_div (
   input  logic        clock,
   input  logic [63:0] in_num,
   input  logic [31:0] in_den,
   output logic [33:0] out_quo,
   output logic [31:0] out_rem,
   output logic [31:0] out_den
);

   localparam int unsigned Steps = vtpo_pkg::DivSteps;

   logic [31:0] src_rem [Steps];
   logic [33:0] src_quo [Steps];
   logic [33:0] src_num [Steps];
   logic [31:0] src_den [Steps];
   logic [32:0] trial [Steps];
   logic        ge [Steps];
   logic [31:0] rem_in [Steps];
   logic [33:0] quo_in [Steps];
   logic [33:0] num_in [Steps];
   logic [31:0] rem_ff [Steps];
   logic [33:0] quo_ff [Steps];
   logic [33:0] num_ff [Steps];
   logic [31:0] den_ff [Steps];

   always_comb begin
      src_rem[0] = {2'b00, in_num[63:34]};
      src_quo[0] = '0;
      src_num[0] = in_num[33:0];
      src_den[0] = in_den;
      for (int k = 1; k < Steps; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_quo[k] = quo_ff[k-1];
         src_num[k] = num_ff[k-1];
         src_den[k] = den_ff[k-1];
      end
      for (int k = 0; k < Steps; k++) begin
         trial[k]  = {src_rem[k], src_num[k][33]};
         ge[k]     = trial[k] >= {1'b0, src_den[k]};
         rem_in[k] = ge[k] ? 32'(trial[k] - {1'b0, src_den[k]}) : trial[k][31:0];
         quo_in[k] = {src_quo[k][32:0], ge[k]};
         num_in[k] = {src_num[k][32:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Steps; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         num_ff[k] <= num_in[k];
         den_ff[k] <= src_den[k];
      end
   end

   assign out_quo = quo_ff[Steps-1];
   assign out_rem = rem_ff[Steps-1];
   assign out_den = den_ff[Steps-1];

endmodule

FILE: rtl/vertex_transform_project_outcode.sv
// Vertex transform, perspective projection and clip outcode.
// Input: a word is taken on req_* at each rising edge with start high and
// busy low. busy is held low, so a vertex may be offered every cycle.
// Output: each result word appears on rsp_* for exactly one cycle with
// rsp_valid high, in input order. Throughput is one vertex per cycle.
// Three 34-step restoring dividers (inverse depth, screen x, screen y)
// run side by side behind a three-stage multiply-add and two set-up
// stages. Configuration: csr_write_enable with csr_index and csr_data
// writes one register per edge; the user must make writes only while no
// vertex is in flight, which the block does not enforce. Reset clears the
// configuration registers and the valid flags, which empties the pipeline;
// no result word appears until a vertex is taken after reset. The
// receiver cannot stall the output, so nothing is held back.
module vertex_transform_project_outcode (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic               req_transform_wanted,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_cam_x,
   output logic signed [31:0] rsp_cam_y,
   output logic signed [31:0] rsp_cam_z,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_inverse_depth,
   output logic [3:0]         rsp_outcode,
   output logic               rsp_projected,
   output logic               rsp_skipped,
   output logic               rsp_saturated,
   output logic               rsp_last_out,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int unsigned Steps = vtpo_pkg::DivSteps;

   vtpo_pkg::matrix_type row_ff;
   logic [31:0] half_window_ff;
   logic        clip_mode_ff;

   logic              cam_valid;
   vtpo_pkg::cam_type cam;

   logic [31:0]        abs_x, abs_y, abs_z;
   logic [15:0]        wx, wy;
   vtpo_pkg::side_type side4_in;
   vtpo_pkg::side_type side4_ff;
   logic               valid4_ff;
   logic [47:0]        prodx4_ff, prody4_ff;
   logic [31:0]        den4_ff;

   logic [63:0]        numx, numy;
   vtpo_pkg::side_type side5_in;
   vtpo_pkg::side_type side5_ff;
   logic               valid5_ff;
   logic [63:0]        numx5_ff, numy5_ff;
   logic [31:0]        den5_ff;

   logic [33:0] quo_x, quo_y, quo_i;
   logic [31:0] rem_x, rem_y, rem_i;
   logic [31:0] den_x, den_y, den_i;

   vtpo_pkg::side_type side_dly_ff [Steps];
   logic               valid_dly_ff [Steps];
   vtpo_pkg::side_type side_end;

   logic [34:0]        qr_x, qr_y, qr_i;
   logic [33:0]        mag_x_in, mag_y_in;
   vtpo_pkg::side_type side6_ff;
   logic               valid6_ff;
   logic [33:0]        mag_x_ff, mag_y_ff;
   logic [34:0]        qi_ff;

   logic signed [35:0] base_x, base_y, sum_x, sum_y;
   logic signed [31:0] sx, sy, iz;
   logic               sat_x, sat_y, sat_i;

   logic               out_valid_ff;
   logic signed [31:0] out_cam_x_ff, out_cam_y_ff, out_cam_z_ff;
   logic signed [31:0] out_sx_ff, out_sy_ff, out_iz_ff;
   logic [3:0]         out_code_ff;
   logic               out_proj_ff, out_skip_ff, out_sat_ff, out_last_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         half_window_ff <= '0;
         clip_mode_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            vtpo_pkg::RegRow0Xy:     row_ff[0]      <= csr_data;
            vtpo_pkg::RegRow0Zt:     row_ff[1]      <= csr_data;
            vtpo_pkg::RegRow1Xy:     row_ff[2]      <= csr_data;
            vtpo_pkg::RegRow1Zt:     row_ff[3]      <= csr_data;
            vtpo_pkg::RegRow2Xy:     row_ff[4]      <= csr_data;
            vtpo_pkg::RegRow2Zt:     row_ff[5]      <= csr_data;
            vtpo_pkg::RegHalfWindow: half_window_ff <= csr_data[31:0];
            vtpo_pkg::RegClipMode:   clip_mode_ff   <= csr_data[0];
            default:                 clip_mode_ff   <= clip_mode_ff;
         endcase
      end
   end

   vtpo_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_x      (req_vertex_x),
      .in_y      (req_vertex_y),
      .in_z      (req_vertex_z),
      .in_wanted (req_transform_wanted),
      .in_last   (req_last_vertex),
      .matrix    (row_ff),
      .clip_mode (clip_mode_ff),
      .out_valid (cam_valid),
      .cam       (cam)
   );

   // magnitudes, signs and window products
   always_comb begin
      wx    = half_window_ff[15:0];
      wy    = half_window_ff[31:16];
      abs_x = cam.cam_x[31] ? 32'(~cam.cam_x + 32'sd1) : cam.cam_x;
      abs_y = cam.cam_y[31] ? 32'(~cam.cam_y + 32'sd1) : cam.cam_y;
      abs_z = cam.cam_z[31] ? 32'(~cam.cam_z + 32'sd1) : cam.cam_z;
      side4_in.cam     = cam;
      side4_in.proj    = cam.wanted && (cam.code == 4'd0);
      side4_in.zero_z  = (cam.cam_z == 32'sd0);
      side4_in.neg_z   = cam.cam_z[31];
      side4_in.zero_nx = (wx == 16'd0) || (cam.cam_x == 32'sd0);
      side4_in.zero_ny = (wy == 16'd0) || (cam.cam_y == 32'sd0);
      side4_in.neg_x   = cam.cam_x[31] ^ cam.cam_z[31];
      side4_in.neg_y   = ~(cam.cam_y[31] ^ cam.cam_z[31]);
      side4_in.wx      = wx;
      side4_in.wy      = wy;
      side4_in.ovf     = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid4_ff <= cam_valid;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      side4_ff  <= side4_in;
      prodx4_ff <= 48'(wx) * 48'(abs_x);
      prody4_ff <= 48'(wy) * 48'(abs_y);
      den4_ff   <= abs_z;
   end

   // quotient above 34 bits saturates in any case
   assign numx = {prodx4_ff, 16'd0};
   assign numy = {prody4_ff, 16'd0};

   always_comb begin
      side5_in        = side4_ff;
      side5_in.ovf[0] = {2'b00, numx[63:34]} >= den4_ff;
      side5_in.ovf[1] = {2'b00, numy[63:34]} >= den4_ff;
      side5_in.ovf[2] = {2'b00, vtpo_pkg::InvNum[63:34]} >= den4_ff;
   end

   always_ff @(posedge clock) begin
      side5_ff <= side5_in;
      numx5_ff <= numx;
      numy5_ff <= numy;
      den5_ff  <= den4_ff;
   end

   vtpo_div u_div_x (
      .clock   (clock),
      .in_num  (numx5_ff),
      .in_den  (den5_ff),
      .out_quo (quo_x),
      .out_rem (rem_x),
      .out_den (den_x)
   );

   vtpo_div u_div_y (
      .clock   (clock),
      .in_num  (numy5_ff),
      .in_den  (den5_ff),
      .out_quo (quo_y),
      .out_rem (rem_y),
      .out_den (den_y)
   );

   vtpo_div u_div_i (
      .clock   (clock),
      .in_num  (vtpo_pkg::InvNum),
      .in_den  (den5_ff),
      .out_quo (quo_i),
      .out_rem (rem_i),
      .out_den (den_i)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Steps; k++) begin
            valid_dly_ff[k] <= 1'b0;
         end
      end else begin
         valid_dly_ff[0] <= valid5_ff;
         for (int k = 1; k < Steps; k++) begin
            valid_dly_ff[k] <= valid_dly_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_dly_ff[0] <= side5_ff;
      for (int k = 1; k < Steps; k++) begin
         side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   assign side_end = side_dly_ff[Steps-1];

   // round half away from zero on magnitudes, then cap
   always_comb begin
      qr_x = 35'(quo_x) + 35'({rem_x, 1'b0} >= {1'b0, den_x});
      qr_y = 35'(quo_y) + 35'({rem_y, 1'b0} >= {1'b0, den_y});
      qr_i = 35'(quo_i) + 35'({rem_i, 1'b0} >= {1'b0, den_i});
      if (side_end.zero_z) begin
         mag_x_in = side_end.zero_nx ? 34'd0 : vtpo_pkg::TermCap[33:0];
      end else if (side_end.ovf[0] || (qr_x > vtpo_pkg::TermCap)) begin
         mag_x_in = vtpo_pkg::TermCap[33:0];
      end else begin
         mag_x_in = qr_x[33:0];
      end
      if (side_end.zero_z) begin
         mag_y_in = side_end.zero_ny ? 34'd0 : vtpo_pkg::TermCap[33:0];
      end else if (side_end.ovf[1] || (qr_y > vtpo_pkg::TermCap)) begin
         mag_y_in = vtpo_pkg::TermCap[33:0];
      end else begin
         mag_y_in = qr_y[33:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid6_ff    <= valid_dly_ff[Steps-1];
         out_valid_ff <= valid6_ff;
      end
   end

   always_ff @(posedge clock) begin
      side6_ff <= side_end;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      qi_ff    <= qr_i;
   end

   always_comb begin
      base_x = 36'sd0;
      base_y = 36'sd0;
      base_x[31:16] = side6_ff.wx;
      base_y[31:16] = side6_ff.wy;
      sum_x = side6_ff.neg_x ? base_x - 36'(mag_x_ff) : base_x + 36'(mag_x_ff);
      sum_y = side6_ff.neg_y ? base_y - 36'(mag_y_ff) : base_y + 36'(mag_y_ff);
      if (sum_x > 36'sd2147483647) begin
         sx = 32'sh7fff_ffff;
         sat_x = 1'b1;
      end else if (sum_x < -36'sd2147483648) begin
         sx = 32'sh8000_0000;
         sat_x = 1'b1;
      end else begin
         sx = sum_x[31:0];
         sat_x = 1'b0;
      end
      if (sum_y > 36'sd2147483647) begin
         sy = 32'sh7fff_ffff;
         sat_y = 1'b1;
      end else if (sum_y < -36'sd2147483648) begin
         sy = 32'sh8000_0000;
         sat_y = 1'b1;
      end else begin
         sy = sum_y[31:0];
         sat_y = 1'b0;
      end
      if (side6_ff.zero_z) begin
         iz = 32'sh7fff_ffff;
         sat_i = 1'b1;
      end else if (side6_ff.neg_z) begin
         if (side6_ff.ovf[2] || (qi_ff > 35'h0_8000_0000)) begin
            iz = 32'sh8000_0000;
            sat_i = 1'b1;
         end else begin
            iz = 32'(35'd0 - qi_ff);
            sat_i = 1'b0;
         end
      end else begin
         if (side6_ff.ovf[2] || (qi_ff > 35'h0_7fff_ffff)) begin
            iz = 32'sh7fff_ffff;
            sat_i = 1'b1;
         end else begin
            iz = qi_ff[31:0];
            sat_i = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_last_ff <= side6_ff.cam.last;
      out_skip_ff <= ~side6_ff.cam.wanted;
      out_proj_ff <= side6_ff.proj;
      out_sat_ff  <= side6_ff.cam.wanted && (side6_ff.cam.cam_sat
                     || (side6_ff.proj && (sat_x || sat_y || sat_i)));
      out_code_ff  <= side6_ff.cam.wanted ? side6_ff.cam.code : 4'd0;
      out_cam_x_ff <= side6_ff.cam.wanted ? side6_ff.cam.cam_x : 32'sd0;
      out_cam_y_ff <= side6_ff.cam.wanted ? side6_ff.cam.cam_y : 32'sd0;
      out_cam_z_ff <= side6_ff.cam.wanted ? side6_ff.cam.cam_z : 32'sd0;
      out_sx_ff    <= side6_ff.proj ? sx : 32'sd0;
      out_sy_ff    <= side6_ff.proj ? sy : 32'sd0;
      out_iz_ff    <= side6_ff.proj ? iz : 32'sd0;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_cam_x         = out_cam_x_ff;
   assign rsp_cam_y         = out_cam_y_ff;
   assign rsp_cam_z         = out_cam_z_ff;
   assign rsp_screen_x      = out_sx_ff;
   assign rsp_screen_y      = out_sy_ff;
   assign rsp_inverse_depth = out_iz_ff;
   assign rsp_outcode       = out_code_ff;
   assign rsp_projected     = out_proj_ff;
   assign rsp_skipped       = out_skip_ff;
   assign rsp_saturated     = out_sat_ff;
   assign rsp_last_out      = out_last_ff;

`ifndef SYNTH
   a_skip_not_proj : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_skipped && rsp_projected))
      else $error("skipped word marked projected");

   a_unproj_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_projected) |->
         (rsp_screen_x == 32'sd0 && rsp_screen_y == 32'sd0 && rsp_inverse_depth == 32'sd0))
      else $error("projection fields set on word not projected");

   a_proj_inside : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_projected) |-> (rsp_outcode == 4'd0))
      else $error("projected word outside the view volume");

   a_zero_depth_sat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_projected && rsp_cam_z == 32'sd0) |-> rsp_saturated)
      else $error("zero depth projection not flagged");
`endif

endmodule

FILE: tb/tb_vertex_transform_project_outcode.sv
`timescale 1ns / 100ps

module tb_vertex_transform_project_outcode;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               wanted;
      logic               last;
   } vertex_type;

   typedef struct {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] inv_depth;
      logic [3:0]         outcode;
      logic               projected;
      logic               skipped;
      logic               saturated;
      logic               last;
   } vertex_out_type;

   localparam int unsigned StallLimit = 4000;
   localparam int unsigned DrainCycles = 60;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_vertex_x = '0;
   logic signed [31:0] req_vertex_y = '0;
   logic signed [31:0] req_vertex_z = '0;
   logic               req_transform_wanted = 1'b0;
   logic               req_last_vertex = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_cam_x;
   logic signed [31:0] rsp_cam_y;
   logic signed [31:0] rsp_cam_z;
   logic signed [31:0] rsp_screen_x;
   logic signed [31:0] rsp_screen_y;
   logic signed [31:0] rsp_inverse_depth;
   logic [3:0]         rsp_outcode;
   logic               rsp_projected;
   logic               rsp_skipped;
   logic               rsp_saturated;
   logic               rsp_last_out;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;

   vertex_transform_project_outcode uut (.*);

   always #4 clock = ~clock;

   vertex_type     vertex_queue[$];
   vertex_out_type expected_words[$];
   logic [63:0] mat_reg[6];
   logic [31:0] window_reg;
   logic        clip_reg;
   int unsigned idle_pct;
   int unsigned errors;
   int unsigned stall_count;

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit flag);
      if (v > 128'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] transform_row(input int r, input vertex_type v,
                                                       inout bit flag);
      logic signed [127:0] c0, c1, c2, t, acc;
      c0 = $signed(mat_reg[2 * r][31:0]);
      c1 = $signed(mat_reg[2 * r][63:32]);
      c2 = $signed(mat_reg[2 * r + 1][31:0]);
      t  = $signed(mat_reg[2 * r + 1][63:32]);
      acc = (t <<< 16) + c0 * v.x + c1 * v.y + c2 * v.z + 128'sd32768;
      return clamp32(acc >>> 16, flag);
   endfunction

   function automatic logic signed [31:0] screen_coord(input logic [15:0] w,
         input logic signed [31:0] c, input logic signed [31:0] z, input bit sub,
         inout bit flag);
      logic signed [127:0] n, d, q, r, cc, zz;
      bit neg;
      cc = c;
      zz = z;
      n = $signed({112'd0, w}) * (cc < 0 ? -cc : cc) * 128'sd65536;
      neg = cc < 0;
      if (zz == 0) begin
         q = (n == 0) ? 128'sd0 : 128'sd8589934592;
      end else begin
         d = zz < 0 ? -zz : zz;
         q = n / d;
         r = n % d;
         if (2 * r >= d) q = q + 1;
         if (q > 128'sd8589934592) q = 128'sd8589934592;
         if (zz < 0) neg = !neg;
      end
      if (sub) neg = !neg;
      return clamp32(($signed({112'd0, w}) <<< 16) + (neg ? -q : q), flag);
   endfunction

   function automatic logic signed [31:0] recip_depth(input logic signed [31:0] z,
                                                     inout bit flag);
      logic signed [127:0] d, q, r, zz;
      zz = z;
      if (zz == 0) begin
         flag = 1'b1;
         return 32'sh7fff_ffff;
      end
      d = zz < 0 ? -zz : zz;
      q = (128'sd1 <<< 40) / d;
      r = (128'sd1 <<< 40) % d;
      if (2 * r >= d) q = q + 1;
      return clamp32(zz < 0 ? -q : q, flag);
   endfunction

   function automatic vertex_out_type transform_vertex(input vertex_type v);
      vertex_out_type o;
      bit sat;
      logic signed [63:0] cx, cy, cz;
      o = '{default: '0};
      sat = 1'b0;
      o.last = v.last;
      if (!v.wanted) begin
         o.skipped = 1'b1;
         return o;
      end
      o.cam_x = transform_row(0, v, sat);
      o.cam_y = transform_row(1, v, sat);
      o.cam_z = transform_row(2, v, sat);
      cx = o.cam_x;
      cy = o.cam_y;
      cz = o.cam_z;
      if (clip_reg) begin
         o.outcode[0] = cx < -cz;
         o.outcode[1] = cx > cz;
         o.outcode[2] = cy < -cz;
         o.outcode[3] = cy > cz;
      end
      if (o.outcode == 4'd0) begin
         o.projected = 1'b1;
         o.inv_depth = recip_depth(o.cam_z, sat);
         o.screen_x = screen_coord(window_reg[15:0], o.cam_x, o.cam_z, 1'b0, sat);
         o.screen_y = screen_coord(window_reg[31:16], o.cam_y, o.cam_z, 1'b1, sat);
         if (o.cam_z == 0) sat = 1'b1;
      end
      o.saturated = sat;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && vertex_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
         start <= 1'b1;
         req_vertex_x <= vertex_queue[0].x;
         req_vertex_y <= vertex_queue[0].y;
         req_vertex_z <= vertex_queue[0].z;
         req_transform_wanted <= vertex_queue[0].wanted;
         req_last_vertex <= vertex_queue[0].last;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_out_type e;
      vertex_type v;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               e = expected_words.pop_front();
               check_field("cam_x", e.cam_x, rsp_cam_x);
               check_field("cam_y", e.cam_y, rsp_cam_y);
               check_field("cam_z", e.cam_z, rsp_cam_z);
               check_field("screen_x", e.screen_x, rsp_screen_x);
               check_field("screen_y", e.screen_y, rsp_screen_y);
               check_field("inverse_depth", e.inv_depth, rsp_inverse_depth);
               check_field("outcode", e.outcode, rsp_outcode);
               check_field("projected", e.projected, rsp_projected);
               check_field("skipped", e.skipped, rsp_skipped);
               check_field("saturated", e.saturated, rsp_saturated);
               check_field("last_out", e.last, rsp_last_out);
            end
         end
         if (start && !busy) begin
            v = vertex_queue.pop_front();
            expected_words.push_back(transform_vertex(v));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_write_enable) begin
         stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
         $display("[vertex_transform_project_outcode] ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx < vtpo_pkg::RegHalfWindow) mat_reg[idx] = value;
      else if (idx == vtpo_pkg::RegHalfWindow) window_reg = value[31:0];
      else clip_reg = value[0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (vertex_queue.size() == 0 && expected_words.size() == 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_matrix(input logic [31:0] c[12], input logic [31:0] win,
                              input logic clip);
      csr_write(vtpo_pkg::RegRow0Xy, {c[1], c[0]});
      csr_write(vtpo_pkg::RegRow0Zt, {c[3], c[2]});
      csr_write(vtpo_pkg::RegRow1Xy, {c[5], c[4]});
      csr_write(vtpo_pkg::RegRow1Zt, {c[7], c[6]});
      csr_write(vtpo_pkg::RegRow2Xy, {c[9], c[8]});
      csr_write(vtpo_pkg::RegRow2Zt, {c[11], c[10]});
      csr_write(vtpo_pkg::RegHalfWindow, {$urandom, win});
      csr_write(vtpo_pkg::RegClipMode, {$urandom, $urandom} & ~64'd1 | {63'd0, clip});
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic wanted, input logic last);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      v.wanted = wanted;
      v.last = last;
      vertex_queue.push_back(v);
   endtask

   initial begin
      logic [31:0] coef[12];
      logic [31:0] zz, span;
      int unsigned pcts[3] = '{0, 85, 14};
      int kind;
      errors = 0;
      idle_pct = 0;
      stall_count = 0;
      foreach (mat_reg[i]) mat_reg[i] = '0;
      window_reg = '0;
      clip_reg = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset values
      add_vertex(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
      wait_idle();

      // identity with clipping
      coef = '{32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0};
      load_matrix(coef, 32'h00f0_0140, 1'b1);
      add_vertex(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'hfffb_0000, 32'h0, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'h0005_0000, 32'h0, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'h0, 32'hfffb_0000, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0005_0000, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'h0004_0000, 32'hfffc_0000, 32'h0004_0000, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0, 32'h0000_0001, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0, 32'hffff_ffff, 1'b1, 1'b0);
      add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
      add_vertex(32'h1234_5678, 32'h1, 32'h2, 1'b0, 1'b0);
      wait_idle();

      // extreme coefficients, no clipping, full window
      coef = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h1, 32'hffff_ffff, 32'h10000, 32'h0};
      load_matrix(coef, 32'hffff_ffff, 1'b0);
      add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
      add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
      add_vertex(32'h0, 32'h0, 32'h0000_0001, 1'b1, 1'b0);
      add_vertex(32'h8000, 32'h0, 32'hffff_8000, 1'b1, 1'b0);
      add_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 9; phase++) begin
         kind = $urandom_range(0, 2);
         foreach (coef[i]) begin
            if (kind == 0) coef[i] = $urandom_range(0, 32'h3fff) - 32'h2000;
            else coef[i] = any_word();
         end
         if (kind == 0) begin
            coef[0] = coef[0] + 32'h10000;
            coef[5] = coef[5] + 32'h10000;
            coef[10] = coef[10] + 32'h10000;
            coef[11] = $urandom_range(0, 32'h000a_0000);
         end
         load_matrix(coef, (phase == 3) ? 32'h0 : (phase == 4) ? 32'hffff_ffff :
                     $urandom, phase % 3 != 2);
         idle_pct = pcts[phase % 3];
         for (int n = 0; n < 56; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               // well-formed vertex near the view volume
               zz = $urandom_range(32'h100, 32'h0064_0000);
               span = 3 * zz;
               add_vertex($urandom_range(0, span) - span / 2,
                          $urandom_range(0, span) - span / 2,
                          ($urandom_range(0, 7) == 0) ? -zz : zz,
                          $urandom_range(0, 15) != 0, $urandom_range(0, 1));
            end else begin
               add_vertex(any_word(), any_word(), any_word(), $urandom_range(0, 1),
                          $urandom_range(0, 1));
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("[vertex_transform_project_outcode] OK");
      end else begin
         $display("[vertex_transform_project_outcode] ERROR");
      end
      $finish;
   end

endmodule
